>>> src/ajgm_pkg.sv
// Shared types, constants and the arctangent table of the gripper joint map.
package ajgm_pkg;

	localparam int NUM_JOINTS_DEF   = 3;
	localparam int CORDIC_ITERS_DEF = 24;
	localparam int MAX_JOINTS       = 3;
	localparam int JIDX_W           = 2;
	localparam int DW               = 32;
	localparam int QBITS            = 31;
	localparam int SQRT_STEPS       = 31;
	localparam int PADDR_W          = 5;

	localparam logic signed [DW-1:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [DW-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [63:0] ONE_Q32 = 64'sd4294967296;
	localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
	localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;

	typedef enum logic [2:0] {
		REG_SINE_GAIN,
		REG_SINE_OFFSET,
		REG_POS_RATIO_0,
		REG_POS_RATIO_1,
		REG_POS_RATIO_2,
		REG_EFF_RATIO_0,
		REG_EFF_RATIO_1,
		REG_EFF_RATIO_2
	} reg_idx_t;

	typedef struct packed {
		logic signed [DW-1:0] actuator_position;
		logic signed [DW-1:0] actuator_velocity;
		logic signed [DW-1:0] actuator_effort;
	} sample_t;

	typedef struct packed {
		logic [JIDX_W-1:0]    joint_index;
		logic signed [DW-1:0] joint_position;
		logic signed [DW-1:0] joint_velocity;
		logic signed [DW-1:0] joint_effort;
		logic                 velocity_saturated;
		logic                 last_joint;
	} joint_t;

	typedef struct packed {
		logic signed [DW-1:0]            sine_gain;
		logic signed [DW-1:0]            sine_offset;
		logic [MAX_JOINTS-1:0][DW-1:0]   pos_ratio;
		logic [MAX_JOINTS-1:0][DW-1:0]   eff_ratio;
	} cfg_t;

	// per-joint data riding along the angle pipeline
	typedef struct packed {
		logic [JIDX_W-1:0]    jidx;
		logic                 last;
		logic signed [63:0]   num;
		logic signed [DW-1:0] eff;
		logic                 clamp_lo;
		logic                 clamp_hi;
	} side_t;

	// atan(2^-i) in Q1.30, rounded to nearest
	function automatic logic [30:0] atan_q30(input int i);
		logic [30:0] r;
		case (i)
			0: r = 31'd843314857;
			1: r = 31'd497837829;
			2: r = 31'd263043837;
			3: r = 31'd133525159;
			4: r = 31'd67021687;
			5: r = 31'd33543516;
			6: r = 31'd16775851;
			7: r = 31'd8388437;
			8: r = 31'd4194283;
			9: r = 31'd2097149;
			10: r = 31'd1048576;
			11: r = 31'd524288;
			12: r = 31'd262144;
			13: r = 31'd131072;
			14: r = 31'd65536;
			15: r = 31'd32768;
			16: r = 31'd16384;
			17: r = 31'd8192;
			18: r = 31'd4096;
			19: r = 31'd2048;
			20: r = 31'd1024;
			21: r = 31'd512;
			22: r = 31'd256;
			23: r = 31'd128;
			24: r = 31'd64;
			25: r = 31'd32;
			26: r = 31'd16;
			27: r = 31'd8;
			28: r = 31'd4;
			29: r = 31'd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> src/ajgm_front.sv
// Sample hold, per-joint expansion, sine argument, clamp, effort and radicand stages.
module ajgm_front import ajgm_pkg::*; #(
	parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          sample_valid,
	output logic          sample_stall,
	input  sample_t       sample,
	input  cfg_t          cfg,
	output logic          tok_valid,
	output side_t         tok_side,
	output logic signed [30:0] tok_s,
	output logic [60:0]   tok_rad
);

	sample_t            hold_q;
	logic               hold_v_q;
	logic [JIDX_W-1:0]  cnt_q;
	logic               emit, last_emit, accept;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] prod_s1, num_s1, effp_s1;
	logic [JIDX_W-1:0]  jidx_s1;
	logic               last_s1;
	side_t              side_s2, side_s3, side_s4;
	logic signed [30:0] s_s2, s_s3, s_s4;
	logic [60:0]        sq_s3, rad_s4;

	logic signed [63:0] sum;
	logic signed [DW-1:0] je;
	logic signed [61:0] sq_full;

	assign emit         = hold_v_q && adv;
	assign last_emit    = emit && (cnt_q == JIDX_W'(NUM_JOINTS - 1));
	assign sample_stall = hold_v_q && !last_emit;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			hold_v_q <= 1'b1;
			cnt_q    <= '0;
		end else if (last_emit) begin
			hold_v_q <= 1'b0;
		end else if (emit) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= hold_v_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		sum = prod_s1 + $signed({{16{cfg.sine_offset[DW-1]}}, cfg.sine_offset, 16'h0000});
		if ((effp_s1[63:47] == '0) || (effp_s1[63:47] == '1)) begin
			je = effp_s1[47:16];
		end else if (effp_s1[63]) begin
			je = Q_MIN;
		end else begin
			je = Q_MAX;
		end
		sq_full = s_s2 * s_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= hold_q.actuator_position * cfg.sine_gain;
			num_s1  <= cfg.sine_gain * hold_q.actuator_velocity;
			effp_s1 <= hold_q.actuator_effort * $signed(cfg.eff_ratio[cnt_q]);
			jidx_s1 <= cnt_q;
			last_s1 <= (cnt_q == JIDX_W'(NUM_JOINTS - 1));

			side_s2.jidx     <= jidx_s1;
			side_s2.last     <= last_s1;
			side_s2.num      <= num_s1;
			side_s2.eff      <= je;
			side_s2.clamp_lo <= (sum <= -ONE_Q32);
			side_s2.clamp_hi <= (sum >= ONE_Q32);
			s_s2             <= sum[32:2];

			side_s3 <= side_s2;
			s_s3    <= s_s2;
			sq_s3   <= sq_full[60:0];

			side_s4 <= side_s3;
			s_s4    <= s_s3;
			rad_s4  <= ONE_Q60 - sq_s3;
		end
	end

	assign tok_valid = v_s4;
	assign tok_side  = side_s4;
	assign tok_s     = s_s4;
	assign tok_rad   = rad_s4;

endmodule

>>> src/ajgm_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module ajgm_sqrt import ajgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          rad_valid,
	input  side_t         rad_side,
	input  logic signed [30:0] rad_s,
	input  logic [60:0]   rad,
	output logic          root_valid,
	output side_t         root_side,
	output logic signed [30:0] root_s,
	output logic [30:0]   root
);

	logic               v_s    [1:SQRT_STEPS];
	side_t              side_s [1:SQRT_STEPS];
	logic signed [30:0] sarg_s [1:SQRT_STEPS];
	logic [33:0]        rem_s  [1:SQRT_STEPS];
	logic [30:0]        root_s_q [1:SQRT_STEPS];
	logic [61:0]        rad_sq [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic               v_c;
		side_t              side_c;
		logic signed [30:0] sarg_c;
		logic [33:0]        rem_c, remsh, trial;
		logic [30:0]        root_c;
		logic [61:0]        rad_c;

		if (k == 0) begin : g_first
			assign v_c    = rad_valid;
			assign side_c = rad_side;
			assign sarg_c = rad_s;
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = {1'b0, rad};
		end else begin : g_mid
			assign v_c    = v_s[k];
			assign side_c = side_s[k];
			assign sarg_c = sarg_s[k];
			assign rem_c  = rem_s[k];
			assign root_c = root_s_q[k];
			assign rad_c  = rad_sq[k];
		end

		assign remsh = {rem_c[31:0], rad_c[61:60]};
		assign trial = {1'b0, root_c, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_c;
				sarg_s[k+1] <= sarg_c;
				rad_sq[k+1] <= {rad_c[59:0], 2'b00};
				if (remsh >= trial) begin
					rem_s[k+1]    <= remsh - trial;
					root_s_q[k+1] <= {root_c[29:0], 1'b1};
				end else begin
					rem_s[k+1]    <= remsh;
					root_s_q[k+1] <= {root_c[29:0], 1'b0};
				end
			end
		end
	end

	assign root_valid = v_s[SQRT_STEPS];
	assign root_side  = side_s[SQRT_STEPS];
	assign root_s     = sarg_s[SQRT_STEPS];
	assign root       = root_s_q[SQRT_STEPS];

endmodule

>>> src/ajgm_cordic.sv
// Pipelined CORDIC vectoring, one rotation per stage, giving the angle of (cos, sin).
module ajgm_cordic import ajgm_pkg::*; #(
	parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          root_valid,
	input  side_t         root_side,
	input  logic signed [30:0] root_s,
	input  logic [30:0]   root,
	output logic          ang_valid,
	output side_t         ang_side,
	output logic signed [32:0] ang,
	output logic [30:0]   ang_cos
);

	logic               v_s    [1:CORDIC_ITERS];
	side_t              side_s [1:CORDIC_ITERS];
	logic [30:0]        cos_s  [1:CORDIC_ITERS];
	logic signed [33:0] x_s    [1:CORDIC_ITERS];
	logic signed [33:0] y_s    [1:CORDIC_ITERS];
	logic signed [32:0] z_s    [1:CORDIC_ITERS];

	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_rot
		logic               v_c;
		side_t              side_c;
		logic [30:0]        cos_c;
		logic signed [33:0] x_c, y_c, dx, dy;
		logic signed [32:0] z_c, at;

		if (k == 0) begin : g_first
			assign v_c    = root_valid;
			assign side_c = root_side;
			assign cos_c  = root;
			assign x_c    = $signed({3'b000, root});
			assign y_c    = 34'(root_s);
			assign z_c    = '0;
		end else begin : g_mid
			assign v_c    = v_s[k];
			assign side_c = side_s[k];
			assign cos_c  = cos_s[k];
			assign x_c    = x_s[k];
			assign y_c    = y_s[k];
			assign z_c    = z_s[k];
		end

		assign dx = y_c >>> k;
		assign dy = x_c >>> k;
		assign at = $signed({2'b00, atan_q30(k)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_c;
				cos_s[k+1]  <= cos_c;
				if (!y_c[33]) begin
					x_s[k+1] <= x_c + dx;
					y_s[k+1] <= y_c - dy;
					z_s[k+1] <= z_c + at;
				end else begin
					x_s[k+1] <= x_c - dx;
					y_s[k+1] <= y_c + dy;
					z_s[k+1] <= z_c - at;
				end
			end
		end
	end

	assign ang_valid = v_s[CORDIC_ITERS];
	assign ang_side  = side_s[CORDIC_ITERS];
	assign ang       = z_s[CORDIC_ITERS];
	assign ang_cos   = cos_s[CORDIC_ITERS];

endmodule

>>> src/ajgm_div.sv
// Pipelined restoring divider, one quotient bit per stage, 31 quotient bits.
module ajgm_div import ajgm_pkg::*; #(
	parameter int D_W = 32
) (
	input  logic           clk,
	input  logic           adv,
	input  logic [D_W:0]   rem0,
	input  logic [QBITS-1:0] low,
	input  logic [D_W-1:0] den,
	output logic [QBITS-1:0] quo
);

	logic [D_W:0]       rem_s [1:QBITS];
	logic [QBITS-1:0]   low_s [1:QBITS];
	logic [D_W-1:0]     den_s [1:QBITS];
	logic [QBITS-1:0]   quo_s [1:QBITS];

	for (genvar k = 0; k < QBITS; k++) begin : g_bit
		logic [D_W:0]     rem_c, remsh;
		logic [QBITS-1:0] low_c, quo_c;
		logic [D_W-1:0]   den_c;

		if (k == 0) begin : g_first
			assign rem_c = rem0;
			assign low_c = low;
			assign den_c = den;
			assign quo_c = '0;
		end else begin : g_mid
			assign rem_c = rem_s[k];
			assign low_c = low_s[k];
			assign den_c = den_s[k];
			assign quo_c = quo_s[k];
		end

		assign remsh = {rem_c[D_W-1:0], low_c[QBITS-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				low_s[k+1] <= {low_c[QBITS-2:0], 1'b0};
				den_s[k+1] <= den_c;
				if (remsh >= {1'b0, den_c}) begin
					rem_s[k+1] <= remsh - {1'b0, den_c};
					quo_s[k+1] <= {quo_c[QBITS-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= remsh;
					quo_s[k+1] <= {quo_c[QBITS-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_s[QBITS];

endmodule

>>> src/ajgm_back.sv
// Per-joint ratio scaling: magnitudes, divisor product, range checks, two dividers, sign and saturation.
module ajgm_back import ajgm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  cfg_t          cfg,
	input  logic          ang_valid,
	input  side_t         ang_side,
	input  logic signed [32:0] ang,
	input  logic [30:0]   ang_cos,
	output logic          res_valid,
	output joint_t        res
);

	typedef struct packed {
		logic [JIDX_W-1:0]    jidx;
		logic                 last;
		logic signed [DW-1:0] eff;
		logic                 neg_p;
		logic                 neg_v;
		logic                 zero_p;
		logic                 ovf_p;
		logic                 az_p;
		logic                 zero_v;
		logic                 ovf_v;
		logic                 nz_v;
	} tail_t;

	logic signed [32:0]   ang_f;
	logic [30:0]          cos_f;
	logic signed [DW-1:0] r;

	logic                 v_s1, v_s2;
	logic [30:0]          mag_a_s1;
	logic [DW-1:0]        mag_r_s1;
	logic [62:0]          mag_n_s1;
	logic [61:0]          ud_s1;
	logic                 neg_p_s1, neg_v_s1;
	side_t                side_s1;
	tail_t                tail_s2;
	logic [DW:0]          rem_p_s2;
	logic [QBITS-1:0]     low_p_s2;
	logic [DW-1:0]        den_p_s2;
	logic [62:0]          rem_v_s2;
	logic [QBITS-1:0]     low_v_s2;
	logic [61:0]          den_v_s2;

	logic                 v_t [1:QBITS];
	tail_t                tail_t_s [1:QBITS];
	logic [QBITS-1:0]     q_p, q_v;
	logic signed [DW-1:0] sat_p, sat_v, jp, jv;
	tail_t                tl;
	logic [62:0]          ud_full;

	always_comb begin
		if (ang_side.clamp_lo) begin
			ang_f = -HALF_PI_Q30;
			cos_f = '0;
		end else if (ang_side.clamp_hi) begin
			ang_f = HALF_PI_Q30;
			cos_f = '0;
		end else begin
			ang_f = ang;
			cos_f = ang_cos;
		end
		r = $signed(cfg.pos_ratio[ang_side.jidx]);
	end

	assign ud_full = cos_f * (r[DW-1] ? DW'(-r) : DW'(r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ang_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_a_s1 <= ang_f[32] ? 31'(-ang_f) : 31'(ang_f);
			mag_r_s1 <= r[DW-1] ? DW'(-r) : DW'(r);
			mag_n_s1 <= ang_side.num[63] ? 63'(-ang_side.num) : 63'(ang_side.num);
			ud_s1    <= ud_full[61:0];
			neg_p_s1 <= ang_f[32] != r[DW-1];
			neg_v_s1 <= ang_side.num[63] != r[DW-1];
			side_s1  <= ang_side;

			tail_s2.jidx   <= side_s1.jidx;
			tail_s2.last   <= side_s1.last;
			tail_s2.eff    <= side_s1.eff;
			tail_s2.neg_p  <= neg_p_s1;
			tail_s2.neg_v  <= neg_v_s1;
			tail_s2.zero_p <= (mag_r_s1 == '0);
			tail_s2.ovf_p  <= ({30'd0, mag_a_s1} >= {mag_r_s1, 29'd0});
			tail_s2.az_p   <= (mag_a_s1 == '0);
			tail_s2.zero_v <= (ud_s1 == '0);
			tail_s2.ovf_v  <= (mag_n_s1 >= {ud_s1, 1'b0});
			tail_s2.nz_v   <= (mag_n_s1 == '0);
			rem_p_s2 <= {31'd0, mag_a_s1[30:29]};
			low_p_s2 <= {mag_a_s1[28:0], 2'b00};
			den_p_s2 <= mag_r_s1;
			rem_v_s2 <= {1'b0, mag_n_s1[62:1]};
			low_v_s2 <= {mag_n_s1[0], 30'd0};
			den_v_s2 <= ud_s1;
		end
	end

	ajgm_div #(.D_W(DW)) u_div_pos (
		.clk  (clk),
		.adv  (adv),
		.rem0 (rem_p_s2),
		.low  (low_p_s2),
		.den  (den_p_s2),
		.quo  (q_p)
	);

	ajgm_div #(.D_W(62)) u_div_vel (
		.clk  (clk),
		.adv  (adv),
		.rem0 (rem_v_s2),
		.low  (low_v_s2),
		.den  (den_v_s2),
		.quo  (q_v)
	);

	// flags line up with the divider stages
	for (genvar k = 0; k < QBITS; k++) begin : g_tail
		logic  v_c;
		tail_t t_c;
		if (k == 0) begin : g_first
			assign v_c = v_s2;
			assign t_c = tail_s2;
		end else begin : g_mid
			assign v_c = v_t[k];
			assign t_c = tail_t_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_t[k+1] <= 1'b0;
			end else if (adv) begin
				v_t[k+1] <= v_c;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				tail_t_s[k+1] <= t_c;
			end
		end
	end

	always_comb begin
		tl    = tail_t_s[QBITS];
		sat_p = tl.neg_p ? Q_MIN : Q_MAX;
		sat_v = tl.neg_v ? Q_MIN : Q_MAX;
		if (tl.zero_p) begin
			jp = tl.az_p ? '0 : sat_p;
		end else if (tl.ovf_p) begin
			jp = sat_p;
		end else if (tl.neg_p) begin
			jp = -$signed({1'b0, q_p});
		end else begin
			jp = $signed({1'b0, q_p});
		end
		if (tl.zero_v) begin
			jv = tl.nz_v ? '0 : sat_v;
		end else if (tl.ovf_v) begin
			jv = sat_v;
		end else if (tl.neg_v) begin
			jv = -$signed({1'b0, q_v});
		end else begin
			jv = $signed({1'b0, q_v});
		end
		res.joint_index        = tl.jidx;
		res.joint_position     = jp;
		res.joint_velocity     = jv;
		res.joint_effort       = tl.eff;
		res.velocity_saturated = tl.zero_v || tl.ovf_v;
		res.last_joint         = tl.last;
	end

	assign res_valid = v_t[QBITS];

endmodule

>>> src/actuator_to_joint_gripper_map.sv
// Top level of the gripper actuator-to-joint map: registers, pipeline chain, output register.
//
//   channel   | signals                              | carries
//   ----------+--------------------------------------+-------------------------------
//   sample    | sample_valid, sample_stall, sample   | actuator position/velocity/effort
//   joint     | joint_valid, joint_stall, joint      | one result per joint
//   config    | psel penable pwrite paddr pwdata ... | eight 32-bit registers at 4*i
//
// A sample is held until a token has been issued for each joint; one joint result
// leaves per cycle unless joint_stall holds it. Tokens pass the front, square-root,
// CORDIC and back stages with the dividers, then the output register.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
// Reset clears valid bits and restores the register defaults; no clearing pass.
module actuator_to_joint_gripper_map import ajgm_pkg::*; #(
	parameter int NUM_JOINTS   = NUM_JOINTS_DEF,
	parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample,
	output logic               joint_valid,
	input  logic               joint_stall,
	output joint_t             joint,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DW-1:0]      pwdata,
	output logic [DW-1:0]      prdata,
	output logic               pready
);

	cfg_t               cfg_q;
	logic               joint_valid_q;
	joint_t             joint_q;
	logic               adv;
	reg_idx_t           ridx;

	logic               f_valid, r_valid, c_valid, b_valid;
	side_t              f_side, r_side, c_side;
	logic signed [30:0] f_s, r_s;
	logic [60:0]        f_rad;
	logic [30:0]        r_root, c_cos;
	logic signed [32:0] c_ang;
	joint_t             b_res;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign adv    = !joint_valid_q || !joint_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sine_gain   <= 32'sd65536;
			cfg_q.sine_offset <= '0;
			cfg_q.pos_ratio   <= {MAX_JOINTS{32'd65536}};
			cfg_q.eff_ratio   <= {MAX_JOINTS{32'd65536}};
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_SINE_GAIN:   cfg_q.sine_gain    <= pwdata;
				REG_SINE_OFFSET: cfg_q.sine_offset  <= pwdata;
				REG_POS_RATIO_0: cfg_q.pos_ratio[0] <= pwdata;
				REG_POS_RATIO_1: cfg_q.pos_ratio[1] <= pwdata;
				REG_POS_RATIO_2: cfg_q.pos_ratio[2] <= pwdata;
				REG_EFF_RATIO_0: cfg_q.eff_ratio[0] <= pwdata;
				REG_EFF_RATIO_1: cfg_q.eff_ratio[1] <= pwdata;
				REG_EFF_RATIO_2: cfg_q.eff_ratio[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_SINE_GAIN:   prdata = cfg_q.sine_gain;
			REG_SINE_OFFSET: prdata = cfg_q.sine_offset;
			REG_POS_RATIO_0: prdata = cfg_q.pos_ratio[0];
			REG_POS_RATIO_1: prdata = cfg_q.pos_ratio[1];
			REG_POS_RATIO_2: prdata = cfg_q.pos_ratio[2];
			REG_EFF_RATIO_0: prdata = cfg_q.eff_ratio[0];
			REG_EFF_RATIO_1: prdata = cfg_q.eff_ratio[1];
			REG_EFF_RATIO_2: prdata = cfg_q.eff_ratio[2];
			default:         prdata = '0;
		endcase
	end

	ajgm_front #(.NUM_JOINTS(NUM_JOINTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.cfg          (cfg_q),
		.tok_valid    (f_valid),
		.tok_side     (f_side),
		.tok_s        (f_s),
		.tok_rad      (f_rad)
	);

	ajgm_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.rad_valid  (f_valid),
		.rad_side   (f_side),
		.rad_s      (f_s),
		.rad        (f_rad),
		.root_valid (r_valid),
		.root_side  (r_side),
		.root_s     (r_s),
		.root       (r_root)
	);

	ajgm_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.root_valid (r_valid),
		.root_side  (r_side),
		.root_s     (r_s),
		.root       (r_root),
		.ang_valid  (c_valid),
		.ang_side   (c_side),
		.ang        (c_ang),
		.ang_cos    (c_cos)
	);

	ajgm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.ang_valid (c_valid),
		.ang_side  (c_side),
		.ang       (c_ang),
		.ang_cos   (c_cos),
		.res_valid (b_valid),
		.res       (b_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_valid_q <= 1'b0;
		end else if (adv) begin
			joint_valid_q <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			joint_q <= b_res;
		end
	end

	assign joint_valid = joint_valid_q;
	assign joint       = joint_q;

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		joint_valid_q && joint_q.last_joint |->
			joint_q.joint_index == JIDX_W'(NUM_JOINTS - 1))
		else $error("last joint flag on wrong joint index");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		joint_valid_q && !joint_q.last_joint |->
			joint_q.joint_index < JIDX_W'(NUM_JOINTS - 1))
		else $error("joint index beyond joint count");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		joint_valid_q && joint_q.velocity_saturated |->
			(joint_q.joint_velocity == Q_MAX || joint_q.joint_velocity == Q_MIN ||
			 joint_q.joint_velocity == '0))
		else $error("saturated velocity not at an extreme");

endmodule
